FILE: src/flat_trie_dictionary_match_count_defines.svh
// ----------------------------------------------------------------------------
// Flat trie match counter assertion macros
// Shared concurrent assertion forms, clocked on clk; the first is quiet during rst.
// ----------------------------------------------------------------------------
`ifndef FLAT_TRIE_DICTIONARY_MATCH_COUNT_DEFINES_SVH
`define FLAT_TRIE_DICTIONARY_MATCH_COUNT_DEFINES_SVH

// check a property on every clock edge outside reset
`define FTD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// check a property on every clock edge, reset included
`define FTD_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: src/ftd_pkg.sv
// ----------------------------------------------------------------------------
// Flat trie match counter package
// Payload structs, command and state codes, and sizes shared by all modules.
// ----------------------------------------------------------------------------
`default_nettype none
package ftd_pkg;

  localparam int NODE_DEPTH   = 4096;
  localparam int NODE_AW      = 12;
  localparam int MAX_WORD_LEN = 256;
  localparam int QUEUE_DEPTH  = 4;
  localparam int QUEUE_AW     = 2;

  localparam logic REQ_NODE = 1'b0;
  localparam logic REQ_TEXT = 1'b1;

  typedef struct packed {
    logic                   req_type;
    logic [NODE_AW-1:0]     node_index;
    logic [7:0]             node_char;
    logic [NODE_AW-1:0]     node_first_child;
    logic [8:0]             node_child_count;
    logic                   node_terminal;
    logic [7:0]             text_byte;
    logic                   text_last;
  } req_t;

  typedef struct packed {
    logic [15:0] match_count;
    logic        word_overflow;
  } rsp_t;

  typedef enum logic [1:0] {
    CMD_NODE,
    CMD_BYTE,
    CMD_STOP
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t          kind;
    logic               last;
    logic [NODE_AW-1:0] node_index;
    logic [7:0]         node_char;
    logic [NODE_AW-1:0] first_child;
    logic [8:0]         child_count;
    logic               terminal;
    logic [7:0]         text_byte;
  } cmd_t;

  typedef struct packed {
    logic [7:0]         label;
    logic [NODE_AW-1:0] first_child;
    logic [8:0]         child_count;
    logic               terminal;
  } node_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_BEGIN,
    S_LOAD,
    S_SEARCH,
    S_CMP,
    S_TEXT,
    S_DONE
  } back_state_t;

  typedef struct packed {
    logic [QUEUE_AW:0] count;
  } front_stat_t;

  typedef struct packed {
    logic cmd_ready;
    logic result_load;
  } back_stat_t;

endpackage
`default_nettype wire

FILE: src/ftd_front.sv
// ----------------------------------------------------------------------------
// Flat trie match counter front end
// Accepts requests, classifies them into commands and queues them.
// ----------------------------------------------------------------------------
`default_nettype none
module ftd_front
  import ftd_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire req_t        in_data,
  output logic             cmd_valid,
  input  wire logic        cmd_ready,
  output cmd_t             cmd,
  output front_stat_t      stat
);

  cmd_t                  queue [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0]   wr_ptr;
  logic [QUEUE_AW-1:0]   rd_ptr;
  logic [QUEUE_AW:0]     count;
  logic                  push;
  logic                  pop;
  cmd_t                  cmd_in;

  always_comb begin
    cmd_in.last        = in_data.text_last;
    cmd_in.node_index  = in_data.node_index;
    cmd_in.node_char   = in_data.node_char;
    cmd_in.first_child = in_data.node_first_child;
    cmd_in.child_count = in_data.node_child_count;
    cmd_in.terminal    = in_data.node_terminal;
    cmd_in.text_byte   = in_data.text_byte;
    if (in_data.req_type == REQ_NODE) begin
      cmd_in.kind = CMD_NODE;
    end else if (in_data.text_byte == 8'd0) begin
      cmd_in.kind = CMD_STOP;
    end else begin
      cmd_in.kind = CMD_BYTE;
    end
  end

  assign in_ready   = (count != (QUEUE_AW+1)'(QUEUE_DEPTH));
  assign cmd_valid  = (count != '0);
  assign push       = in_valid && in_ready;
  assign pop        = cmd_valid && cmd_ready;
  assign cmd        = queue[rd_ptr];
  assign stat.count = count;

  always_ff @(posedge clk) begin
    if (push) begin
      queue[wr_ptr] <= cmd_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

FILE: src/ftd_back.sv
// ----------------------------------------------------------------------------
// Flat trie match counter back end
// Holds the node table and word buffer, runs the walks, registers results.
// ----------------------------------------------------------------------------
`default_nettype none
module ftd_back
  import ftd_pkg::*;
#(
  parameter int MAX_WORD_LEN = ftd_pkg::MAX_WORD_LEN
) (
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire logic   cmd_valid,
  input  wire cmd_t   cmd,
  output back_stat_t  stat,
  output logic        out_valid,
  input  wire logic   out_ready,
  output rsp_t        out_data
);

  localparam int AW = (MAX_WORD_LEN > 1) ? $clog2(MAX_WORD_LEN) : 1;
  localparam int LW = $clog2(MAX_WORD_LEN + 1);

  node_t              node_mem [NODE_DEPTH];
  logic [7:0]         text_mem [MAX_WORD_LEN];

  back_state_t        state;
  back_state_t        state_next;
  logic [LW-1:0]      len;
  logic [LW-1:0]      len_next;
  logic               ended;
  logic               ended_next;
  logic               ovf;
  logic               ovf_next;
  logic [LW-1:0]      start;
  logic [LW-1:0]      start_next;
  logic [LW-1:0]      pos;
  logic [LW-1:0]      pos_next;
  logic [15:0]        total;
  logic [15:0]        total_next;
  logic [NODE_AW:0]   lo;
  logic [NODE_AW:0]   lo_next;
  logic [NODE_AW:0]   hi_end;
  logic [NODE_AW:0]   hi_end_next;
  logic [NODE_AW:0]   mid_q;
  logic [NODE_AW:0]   mid_q_next;
  logic [7:0]         c;
  logic [7:0]         c_next;

  node_t              node_rd;
  logic [7:0]         text_rd;
  logic [NODE_AW-1:0] node_raddr;
  logic [LW-1:0]      text_raddr;

  logic               cmd_pop;
  logic               byte_store;
  logic               go_walk;
  logic [LW-1:0]      len_after;
  logic [LW-1:0]      pos_inc;
  logic [LW-1:0]      start_inc;
  logic [NODE_AW+1:0] mid_sum;
  logic [NODE_AW:0]   mid;
  logic [NODE_AW:0]   child_end;
  logic               probe_ok;
  logic               hit;
  logic               path_end;
  logic               walk_end;
  logic               load;

  assign cmd_pop    = cmd_valid && (state == S_IDLE);
  assign byte_store = cmd_pop && (cmd.kind == CMD_BYTE) && !ended &&
                      (len < LW'(MAX_WORD_LEN));
  assign len_after  = byte_store ? len + 1'b1 : len;
  assign go_walk    = cmd_pop && (cmd.kind != CMD_NODE) && cmd.last;
  assign pos_inc    = pos + 1'b1;
  assign start_inc  = start + 1'b1;
  assign mid_sum    = {1'b0, lo} + {1'b0, hi_end} - (NODE_AW+2)'(1);
  assign mid        = mid_sum[NODE_AW+1:1];
  assign child_end  = {1'b0, node_rd.first_child} + (NODE_AW+1)'(node_rd.child_count);
  assign probe_ok   = (lo < hi_end);
  assign hit        = (node_rd.label == c);
  assign path_end   = (pos_inc >= len);
  assign walk_end   = (start_inc >= len);
  assign load       = (state == S_DONE) && (!out_valid || out_ready);

  assign stat.cmd_ready   = (state == S_IDLE);
  assign stat.result_load = load;

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (go_walk) begin
          state_next = (len_after == '0) ? S_DONE : S_BEGIN;
        end
      end
      S_BEGIN:  state_next = S_LOAD;
      S_LOAD:   state_next = S_SEARCH;
      S_SEARCH: begin
        if (probe_ok) begin
          state_next = S_CMP;
        end else begin
          state_next = walk_end ? S_DONE : S_BEGIN;
        end
      end
      S_CMP: begin
        if (!hit) begin
          state_next = S_SEARCH;
        end else if (path_end) begin
          state_next = walk_end ? S_DONE : S_BEGIN;
        end else begin
          state_next = S_TEXT;
        end
      end
      S_TEXT:   state_next = S_SEARCH;
      S_DONE: begin
        if (load) begin
          state_next = S_IDLE;
        end
      end
      default:  state_next = S_IDLE;
    endcase
  end

  always_comb begin
    len_next    = len;
    ended_next  = ended;
    ovf_next    = ovf;
    start_next  = start;
    pos_next    = pos;
    total_next  = total;
    lo_next     = lo;
    hi_end_next = hi_end;
    mid_q_next  = mid_q;
    c_next      = c;
    node_raddr  = '0;
    text_raddr  = start;
    case (state)
      S_IDLE: begin
        len_next = len_after;
        if (cmd_pop && (cmd.kind == CMD_BYTE) && !ended &&
            (len == LW'(MAX_WORD_LEN))) begin
          ovf_next = 1'b1;
        end
        if (cmd_pop && (cmd.kind == CMD_STOP)) begin
          ended_next = 1'b1;
        end
        if (go_walk) begin
          start_next = '0;
          total_next = '0;
        end
      end
      S_BEGIN: begin
        pos_next   = start;
        node_raddr = '0;
        text_raddr = start;
      end
      S_LOAD: begin
        lo_next     = {1'b0, node_rd.first_child};
        hi_end_next = child_end;
        c_next      = text_rd;
      end
      S_SEARCH: begin
        mid_q_next = mid;
        node_raddr = mid[NODE_AW-1:0];
        if (!probe_ok) begin
          start_next = start_inc;
        end
      end
      S_CMP: begin
        if (hit) begin
          if (node_rd.terminal && (total != 16'hFFFF)) begin
            total_next = total + 16'd1;
          end
          if (path_end) begin
            start_next = start_inc;
          end else begin
            pos_next    = pos_inc;
            lo_next     = {1'b0, node_rd.first_child};
            hi_end_next = child_end;
            text_raddr  = pos_inc;
          end
        end else if (node_rd.label > c) begin
          hi_end_next = mid_q;
        end else begin
          lo_next = mid_q + 1'b1;
        end
      end
      S_TEXT: begin
        c_next = text_rd;
      end
      S_DONE: begin
        if (load) begin
          len_next   = '0;
          ended_next = 1'b0;
          ovf_next   = 1'b0;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd_pop && (cmd.kind == CMD_NODE)) begin
      node_mem[cmd.node_index] <= '{label:       cmd.node_char,
                                    first_child: cmd.first_child,
                                    child_count: cmd.child_count,
                                    terminal:    cmd.terminal};
    end
    node_rd <= node_mem[node_raddr];
  end

  always_ff @(posedge clk) begin
    if (byte_store) begin
      text_mem[len[AW-1:0]] <= cmd.text_byte;
    end
    text_rd <= text_mem[text_raddr[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    start  <= start_next;
    pos    <= pos_next;
    total  <= total_next;
    lo     <= lo_next;
    hi_end <= hi_end_next;
    mid_q  <= mid_q_next;
    c      <= c_next;
    if (load) begin
      out_data.match_count   <= total;
      out_data.word_overflow <= ovf;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      len       <= '0;
      ended     <= 1'b0;
      ovf       <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      len   <= len_next;
      ended <= ended_next;
      ovf   <= ovf_next;
      if (load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule
`default_nettype wire

FILE: src/flat_trie_dictionary_match_count.sv
// ----------------------------------------------------------------------------
// Flat trie dictionary match counter
// Counts dictionary word occurrences in each text word against a loaded trie.
// ----------------------------------------------------------------------------
// Requests pass through a four-entry command queue, so node writes and text
// bytes are taken one per cycle while the queue has room and the engine is
// idle. The byte marked last starts the walks: each start position fetches
// the root and the byte (S_BEGIN, S_LOAD), each binary-search probe reads the
// node table's single read port (S_SEARCH, S_CMP), each matched step that goes
// on reads the next byte (S_TEXT), and each walk that ends on a miss takes one
// more S_SEARCH pass. A result waits in an output register while the engine
// goes on with queued node writes and bytes.
`default_nettype none
`include "flat_trie_dictionary_match_count_defines.svh"
module flat_trie_dictionary_match_count
  import ftd_pkg::*;
#(
  parameter int MAX_WORD_LEN = ftd_pkg::MAX_WORD_LEN
) (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  in_valid,
  output logic       in_ready,
  input  wire req_t  in_data,
  output logic       out_valid,
  input  wire logic  out_ready,
  output rsp_t       out_data
);

  logic        cmd_valid;
  cmd_t        cmd;
  front_stat_t fstat;
  back_stat_t  bstat;

  ftd_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .cmd_valid (cmd_valid),
    .cmd_ready (bstat.cmd_ready),
    .cmd       (cmd),
    .stat      (fstat)
  );

  ftd_back #(
    .MAX_WORD_LEN (MAX_WORD_LEN)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .stat      (bstat),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  `FTD_ASSERT(a_queue_bound, (fstat.count <= (QUEUE_AW+1)'(QUEUE_DEPTH)), "queue overfilled")
  `FTD_ASSERT(a_full_stalls, ((fstat.count == (QUEUE_AW+1)'(QUEUE_DEPTH)) |-> !in_ready), "accept while queue full")
  `FTD_ASSERT(a_result_source, ($rose(out_valid) |-> $past(bstat.result_load)), "result without walk end")

endmodule
`default_nettype wire

FILE: test/tb_flat_trie_dictionary_match_count.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Flat trie match counter testbench
// Loads small sorted tries into the node table and streams text words. The
// expected match count and overflow flag of each word are computed in the
// bench and compared with every output transfer. Both sides idle at random.
// ----------------------------------------------------------------------------
module tb_flat_trie_dictionary_match_count;
  import ftd_pkg::*;

  logic clk;
  logic rst;
  logic in_valid;
  logic in_ready;
  req_t in_data;
  logic out_valid;
  logic out_ready;
  rsp_t out_data;

  flat_trie_dictionary_match_count dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // bench copy of the node table and word state
  logic [7:0]  trie_label [NODE_DEPTH];
  logic [11:0] trie_first [NODE_DEPTH];
  logic [8:0]  trie_count [NODE_DEPTH];
  logic        trie_term  [NODE_DEPTH];
  logic [7:0]  word_buf [MAX_WORD_LEN];
  int          word_len;
  bit          word_ended;
  bit          word_over;

  req_t pending_reqs[$];
  rsp_t expected_counts[$];
  int   errors;
  int   words_checked;
  int   node_writes;
  int   text_bytes;
  bit   long_hold;
  bit   drain_pause;
  bit   driver_idle;
  int   hold_cycles;

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch %s: got %0d expected %0d", what, got, want);
    errors++;
  endtask

  function automatic bit child_lookup(input int parent, input logic [7:0] c,
                                      output int hit);
    longint lo;
    longint hi;
    longint mid;
    int slot;
    lo = trie_first[parent];
    hi = lo + trie_count[parent] - 1;
    while (lo <= hi) begin
      mid = (lo + hi) / 2;
      slot = int'(mid % NODE_DEPTH);
      if (trie_label[slot] == c) begin
        hit = slot;
        return 1;
      end else if (trie_label[slot] > c) begin
        hi = mid - 1;
      end else begin
        lo = mid + 1;
      end
    end
    return 0;
  endfunction

  function automatic int count_word_matches();
    int total;
    int node;
    int nxt;
    total = 0;
    for (int s = 0; s < word_len; s++) begin
      node = 0;
      for (int p = s; p < word_len; p++) begin
        if (!child_lookup(node, word_buf[p], nxt)) break;
        node = nxt;
        if (trie_term[node] && total < 65535) total++;
      end
    end
    return total;
  endfunction

  task automatic predict_transfer(input req_t r);
    rsp_t e;
    if (r.req_type == REQ_NODE) begin
      trie_label[r.node_index] = r.node_char;
      trie_first[r.node_index] = r.node_first_child;
      trie_count[r.node_index] = r.node_child_count;
      trie_term[r.node_index]  = r.node_terminal;
      node_writes++;
      return;
    end
    text_bytes++;
    if (!word_ended) begin
      if (r.text_byte == 8'd0) word_ended = 1;
      else if (word_len < MAX_WORD_LEN) begin
        word_buf[word_len] = r.text_byte;
        word_len++;
      end else word_over = 1;
    end
    if (r.text_last) begin
      e.match_count   = 16'(count_word_matches());
      e.word_overflow = word_over;
      expected_counts.push_back(e);
      word_len = 0;
      word_ended = 0;
      word_over = 0;
    end
  endtask

  // ---- stimulus helpers ----
  function automatic req_t node_req(input int idx, input int ch, input int first,
                                    input int cnt, input bit term);
    req_t r;
    r = '0;
    r.req_type = REQ_NODE;
    r.node_index = 12'(idx);
    r.node_char = 8'(ch);
    r.node_first_child = 12'(first);
    r.node_child_count = 9'(cnt);
    r.node_terminal = term;
    r.text_byte = 8'($urandom);
    r.text_last = 1'($urandom);
    return r;
  endfunction

  function automatic req_t byte_req(input int b, input bit last);
    req_t r;
    r = req_t'(($bits(req_t))'({$urandom, $urandom}));
    r.req_type = REQ_TEXT;
    r.text_byte = 8'(b);
    r.text_last = last;
    return r;
  endfunction

  // write every node so no walk reads an unwritten entry
  task automatic build_trie(input int nodes, input int alpha);
    int lbl[$];
    int parent_slots[$];
    int next_free;
    int p;
    int plbl;
    int k;
    int step;
    lbl.delete();
    parent_slots.push_back(0);
    lbl.push_back(0);
    next_free = 1;
    pending_reqs.push_back(node_req(0, $urandom, 0, 0, 0));
    while (parent_slots.size() > 0) begin
      p = parent_slots.pop_front();
      plbl = lbl.pop_front();
      k = (next_free < nodes) ? $urandom_range(0, 4) : 0;
      if (next_free + k > nodes) k = nodes - next_free;
      step = $urandom_range(1, (alpha >= 8) ? alpha / 4 : 2);
      pending_reqs.push_back(node_req(p, plbl, next_free, k,
                                      p != 0 && $urandom_range(0, 2) != 0));
      for (int i = 0; i < k; i++) begin
        pending_reqs.push_back(node_req(next_free + i, 1 + i * step, 0, 0, 1));
        parent_slots.push_back(next_free + i);
        lbl.push_back(1 + i * step);
      end
      next_free += k;
    end
  endtask

  task automatic push_word(input int len, input int alpha, input int zero_pct);
    int b;
    for (int i = 0; i < len; i++) begin
      b = $urandom_range(1, alpha);
      if ($urandom_range(0, 99) < zero_pct) b = 0;
      pending_reqs.push_back(byte_req(b, i == len - 1));
    end
  endtask

  // ---- driver ----
  int gap_left;
  int gap_draw;
  bit offer_next;
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      in_data <= '0;
      gap_left <= 0;
      driver_idle <= 1'b1;
    end else begin
      gap_draw = gap_left;
      offer_next = in_valid;
      if (in_valid && in_ready) begin
        predict_transfer(in_data);
        gap_draw = $urandom_range(0, 1) ? 0 : $urandom_range(0, 17);
        offer_next = 1'b0;
      end
      if (!offer_next) begin
        if (gap_draw > 0) begin
          gap_left <= gap_draw - 1;
        end else if (pending_reqs.size() > 0 &&
                     !(drain_pause && expected_counts.size() > 0)) begin
          in_data <= pending_reqs.pop_front();
          offer_next = 1'b1;
          gap_left <= 0;
        end
      end
      in_valid <= offer_next;
      driver_idle <= (pending_reqs.size() == 0) && !offer_next;
    end
  end

  // ---- monitor and receiver ----
  int stall_left;
  int stall_draw;
  rsp_t want;
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      stall_left <= 0;
      hold_cycles <= 0;
    end else begin
      stall_draw = stall_left;
      if (out_valid && out_ready) begin
        words_checked++;
        if (expected_counts.size() == 0) begin
          report_mismatch("unexpected result", out_data.match_count, -1);
        end else begin
          want = expected_counts.pop_front();
          if (out_data.match_count !== want.match_count)
            report_mismatch("match_count", out_data.match_count, want.match_count);
          if (out_data.word_overflow !== want.word_overflow)
            report_mismatch("word_overflow", out_data.word_overflow, want.word_overflow);
        end
        stall_draw = $urandom_range(0, 1) ? 0 : $urandom_range(0, 17);
      end
      if (long_hold && hold_cycles < 3000) begin
        hold_cycles <= hold_cycles + 1;
        stall_left <= stall_draw;
        out_ready <= 1'b0;
      end else if (stall_draw > 0) begin
        stall_left <= stall_draw - 1;
        out_ready <= 1'b0;
      end else begin
        stall_left <= 0;
        out_ready <= 1'b1;
      end
    end
  end

  // ---- watchdog ----
  int quiet_cycles;
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > 20000) begin
      $display("timeout waiting for transfers");
      $display("tb_flat_trie_dictionary_match_count: errors");
      $finish;
    end
  end

  initial begin
    int alpha;
    errors = 0;
    words_checked = 0;
    node_writes = 0;
    text_bytes = 0;
    word_len = 0;
    word_ended = 0;
    word_over = 0;
    long_hold = 0;
    drain_pause = 0;
    rst = 1'b1;
    in_valid = 1'b0;
    in_data = '0;
    out_ready = 1'b0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // directed: root with children 1 and 0xff, a deep child, ignored write
    pending_reqs.push_back(node_req(0, 0, 1, 2, 0));
    pending_reqs.push_back(node_req(1, 1, 3, 1, 1));
    pending_reqs.push_back(node_req(2, 255, 4095, 0, 1));
    pending_reqs.push_back(node_req(3, 2, 0, 0, 1));
    pending_reqs.push_back(node_req(4095, 128, 4094, 0, 0));
    pending_reqs.push_back(byte_req(1, 1));
    pending_reqs.push_back(byte_req(255, 0));
    pending_reqs.push_back(byte_req(1, 0));
    pending_reqs.push_back(byte_req(2, 1));
    pending_reqs.push_back(byte_req(1, 0));
    pending_reqs.push_back(byte_req(0, 0));
    pending_reqs.push_back(byte_req(1, 1));
    pending_reqs.push_back(byte_req(0, 1));
    pending_reqs.push_back(byte_req(7, 1));
    // child range that wraps past the top of the table back onto the root
    pending_reqs.push_back(node_req(0, 0, 4095, 2, 0));
    pending_reqs.push_back(node_req(4095, 5, 0, 0, 1));
    pending_reqs.push_back(node_req(0, 9, 4095, 2, 1));
    pending_reqs.push_back(byte_req(5, 0));
    pending_reqs.push_back(byte_req(9, 1));
    // overflow: one word longer than the buffer, bytes 1 to 9 against the root list
    push_word(MAX_WORD_LEN + 3, 9, 0);

    // random tries and words
    for (int t = 0; t < 14; t++) begin
      alpha = (t % 3 == 0) ? 255 : $urandom_range(3, 12);
      build_trie($urandom_range(2, 40), alpha);
      for (int w = 0; w < 12; w++)
        push_word(($urandom_range(0, 15) == 0) ? $urandom_range(1, 40)
                  : $urandom_range(1, 6), (alpha > 12) ? 255 : alpha + 1,
                  $urandom_range(0, 3) == 0 ? 10 : 0);
      if (t == 4) begin
        wait (pending_reqs.size() == 0);
        long_hold = 1;
        push_word(6, 4, 0);
        for (int w = 0; w < 10; w++) push_word(1, 4, 0);
      end
      if (t == 8) begin
        wait (pending_reqs.size() == 0);
        drain_pause = 1;
        wait (expected_counts.size() == 0);
        drain_pause = 0;
      end
    end
    // an all-0xff trie path for the extreme byte values
    pending_reqs.push_back(node_req(0, 0, 1, 1, 0));
    pending_reqs.push_back(node_req(1, 255, 1, 1, 1));
    push_word(40, 255, 0);
    pending_reqs.push_back(byte_req(255, 1));

    wait (pending_reqs.size() == 0 && driver_idle);
    wait (expected_counts.size() == 0);
    repeat (400) @(posedge clk);
    $display("covered %0d node writes, %0d text bytes, %0d words checked",
             node_writes, text_bytes, words_checked);
    if (errors == 0 && expected_counts.size() == 0) begin
      $display("tb_flat_trie_dictionary_match_count: clean");
    end else begin
      $display("tb_flat_trie_dictionary_match_count: errors");
    end
    $finish;
  end

endmodule
